[src/bounded_ordered_list_engine_unit_assert.svh]
// assertion macros for the ordered list engine
// relies on signals named clock and reset in the module that includes it
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BOLE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define BOLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BOLE_ASSERT_SAME(label, ante, cons)
`define BOLE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/bole_pkg.sv]
// shared constants, command codes and interface structs for the ordered list engine
// no dependencies
`timescale 1ns / 1ps

package bole_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 8;
   localparam int CMD_W    = 3;
   localparam int LENGTH_W = 7;
   localparam int CMP_W    = 9;

   localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REM_VAL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REM_POS   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd4;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage

[src/bounded_ordered_list_engine_unit.sv]
// Ordered list of up to 64 signed 32-bit values kept in one single-port-read,
// single-port-write ram; commands come in one word at a time and each gives one
// status word. A clear, an unknown code or a command that fails on its position or
// full checks goes straight to the result. An insert moves each entry from the tail
// down to position p up one slot and then writes the value at p; a remove at
// position p moves each later entry down one slot; a remove by value compares the
// entries from the head and, on a hit, moves the rest down one slot. The ram moves
// or compares one entry per cycle. A stalled receiver holds the result back. The
// next command is taken once the previous result has reached the output register.
// Depends on bole_pkg, bole_ctrl, bole_ram and the assertion header.
`timescale 1ns / 1ps

`include "bounded_ordered_list_engine_unit_assert.svh"

module bounded_ordered_list_engine_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // position[7:0], value[39:8]
   input  logic [2:0]   req_tuser,   // cmd[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata    // ok[0], length[7:1], is_empty[8], is_full[9]
);

   bole_pkg::mem_req_type           mem_req;
   logic [bole_pkg::VALUE_W-1:0]    mem_rd_data;
   bole_pkg::result_type            res;
   logic                            res_valid;
   logic                            res_ready;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [15:0]                     rsp_data_ff, rsp_data_in;
   logic                            is_empty;
   logic                            is_full;

   bole_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (req_tvalid),
      .cmd_ready   (req_tready),
      .cmd         (req_tuser),
      .position    (req_tdata[7:0]),
      .value       (req_tdata[39:8]),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res         (res),
      .res_valid   (res_valid),
      .res_ready   (res_ready)
   );

   bole_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   assign is_empty  = (res.count == '0);
   assign is_full   = (res.count == bole_pkg::CNT_W'(bole_pkg::CAPACITY));
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b0, is_full, is_empty,
                         res.count[bole_pkg::LENGTH_W-1:0], res.ok};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one command in flight: nothing is taken until its result has left the sequencer
   `BOLE_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)
   // a finished result held back by the output register stays offered
   `BOLE_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid)
   // the sequencer never reports and accepts in the same cycle
   `BOLE_ASSERT_SAME(a_res_vs_ready, res_valid, !req_tready)
   // no write and read of the same entry in one cycle
   `BOLE_ASSERT_SAME(a_no_rw_clash, mem_req.wr_en && mem_req.rd_en,
                     mem_req.wr_addr != mem_req.rd_addr)

endmodule

[src/bole_ram.sv]
// entry storage: one write port and one read port with registered read data
// depends on bole_pkg
`timescale 1ns / 1ps

module bole_ram (
   input  logic                           clock,
   input  bole_pkg::mem_req_type          mem_req,
   output logic [bole_pkg::VALUE_W-1:0]   rd_data
);

   logic [bole_pkg::VALUE_W-1:0] mem [bole_pkg::CAPACITY];
   logic [bole_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bole_ctrl.sv]
// command sequencer: decodes a command, scans and shifts entries through the ram,
// keeps the entry count. depends on bole_pkg
`timescale 1ns / 1ps

module bole_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_valid,
   output logic                           cmd_ready,
   input  logic [bole_pkg::CMD_W-1:0]     cmd,
   input  logic [bole_pkg::POS_W-1:0]     position,
   input  logic [bole_pkg::VALUE_W-1:0]   value,
   output bole_pkg::mem_req_type          mem_req,
   input  logic [bole_pkg::VALUE_W-1:0]   mem_rd_data,
   output bole_pkg::result_type           res,
   output logic                           res_valid,
   input  logic                           res_ready
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS,
      ST_SRCH,
      ST_DEL,
      ST_RESP
   } state_type;

   state_type                      state_ff, state_in;
   logic [bole_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [bole_pkg::CNT_W-1:0]     idx_ff, idx_in;
   logic [bole_pkg::ADDR_W-1:0]    at_ff, at_in;
   logic [bole_pkg::VALUE_W-1:0]   val_ff, val_in;
   logic                           ok_ff, ok_in;
   logic                           pend_ff, pend_in;
   logic [bole_pkg::ADDR_W-1:0]    pend_addr_ff, pend_addr_in;

   logic [bole_pkg::CNT_W-1:0]     idx_dec;
   logic [bole_pkg::CNT_W-1:0]     idx_inc;
   logic                           full;
   logic                           pos_in_list;
   logic                           match;

   assign idx_dec     = idx_ff - 1'b1;
   assign idx_inc     = idx_ff + 1'b1;
   assign full        = (count_ff == bole_pkg::CNT_W'(bole_pkg::CAPACITY));
   assign pos_in_list = (bole_pkg::CMP_W'(position) < bole_pkg::CMP_W'(count_ff));
   assign match       = pend_ff && (mem_rd_data == val_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      at_in        = at_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      mem_req      = '0;
      res_valid    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               val_in = value;
               at_in  = position[bole_pkg::ADDR_W-1:0];
               ok_in  = 1'b0;
               unique case (cmd)
                  bole_pkg::CMD_INS_FRONT: begin
                     at_in    = '0;
                     idx_in   = count_ff;
                     state_in = full ? ST_RESP : ST_INS;
                  end
                  bole_pkg::CMD_INS_POS: begin
                     idx_in   = count_ff;
                     state_in = (!full && (position == '0 || pos_in_list)) ? ST_INS : ST_RESP;
                  end
                  bole_pkg::CMD_REM_VAL: begin
                     idx_in   = '0;
                     state_in = ST_SRCH;
                  end
                  bole_pkg::CMD_REM_POS: begin
                     idx_in   = bole_pkg::CNT_W'(position[bole_pkg::ADDR_W-1:0]) + 1'b1;
                     state_in = pos_in_list ? ST_DEL : ST_RESP;
                  end
                  bole_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // walk down from the tail, each word moves up one slot
         ST_INS: begin
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff + 1'b1;
               mem_req.wr_data = mem_rd_data;
            end
            if (idx_ff > bole_pkg::CNT_W'(at_ff)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_dec[bole_pkg::ADDR_W-1:0];
               pend_in         = 1'b1;
               pend_addr_in    = idx_dec[bole_pkg::ADDR_W-1:0];
               idx_in          = idx_dec;
            end else if (!pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = at_ff;
               mem_req.wr_data = val_ff;
               count_in        = count_ff + 1'b1;
               ok_in           = 1'b1;
               state_in        = ST_RESP;
            end
         end

         // read ahead keeps going on a hit; that read feeds the first shift
         ST_SRCH: begin
            if (idx_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[bole_pkg::ADDR_W-1:0];
               pend_in         = 1'b1;
               pend_addr_in    = idx_ff[bole_pkg::ADDR_W-1:0];
               idx_in          = idx_inc;
            end
            if (match) begin
               state_in = ST_DEL;
            end else if (!pend_ff && idx_ff >= count_ff) begin
               state_in = ST_RESP;
            end
         end

         // walk up from the gap, each word moves down one slot
         ST_DEL: begin
            if (pend_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pend_addr_ff - 1'b1;
               mem_req.wr_data = mem_rd_data;
            end
            if (idx_ff < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = idx_ff[bole_pkg::ADDR_W-1:0];
               pend_in         = 1'b1;
               pend_addr_in    = idx_ff[bole_pkg::ADDR_W-1:0];
               idx_in          = idx_inc;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
               ok_in    = 1'b1;
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      idx_ff       <= idx_in;
      at_ff        <= at_in;
      val_ff       <= val_in;
      ok_ff        <= ok_in;
      pend_addr_ff <= pend_addr_in;
   end

   assign cmd_ready = (state_ff == ST_IDLE);
   assign res.ok    = ok_ff;
   assign res.count = count_ff;

endmodule

[dv/bounded_ordered_list_engine_unit_test.sv]
// self-checking testbench for bounded_ordered_list_engine_unit: directed and random list commands,
// each status word checked against a queue-based list model kept alongside the block
// depends on bole_pkg and the rtl of the ordered list engine
`timescale 1ns / 1ps

module bounded_ordered_list_engine_unit_test;
   import bole_pkg::*;

   localparam logic [CMD_W-1:0] CMD_RSVD_MIN = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_RSVD_MAX = 3'd7;
   localparam int ITEMS_PER_PHASE = 450;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 200;
   localparam int MAX_REPORTS     = 10;

   typedef enum int {PH_DIRECTED, PH_FREE, PH_SEND_IDLE, PH_RSP_STALL, PH_BOTH} phase_type;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      phase_type          phase;
   } list_cmd_type;

   typedef struct packed {
      logic                ok;
      logic [LENGTH_W-1:0] length;
      logic                is_empty;
      logic                is_full;
   } list_status_type;

   int send_idle_pct [5] = '{0, 0, 49, 0, 21};
   int rsp_stall_pct [5] = '{0, 0, 0, 49, 21};

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;   // position[7:0], value[39:8]
   logic [2:0]  req_tuser  = '0;   // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // ok[0], length[7:1], is_empty[8], is_full[9]

   list_cmd_type       cmd_pending[$];
   list_cmd_type       cmd_in_flight;
   list_status_type    status_expected[$];
   logic [VALUE_W-1:0] shadow_list[$];
   phase_type          phase_now = PH_DIRECTED;
   logic               hold_off  = 1'b0;
   int                 words_queued   = 0;
   int                 words_accepted = 0;
   int                 fail_count     = 0;

   bounded_ordered_list_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // applies one command to the shadow list and returns the status it should give
   function automatic list_status_type apply_list_command(list_cmd_type c);
      list_status_type st;
      int len;
      bit found;
      len = shadow_list.size();
      st.ok = 1'b0;
      found = 0;
      case (c.cmd)
         CMD_INS_FRONT: begin
            if (len < CAPACITY) begin
               shadow_list.push_front(c.val);
               st.ok = 1'b1;
            end
         end
         CMD_INS_POS: begin
            if (len < CAPACITY && (c.pos == 0 || int'(c.pos) < len)) begin
               shadow_list.insert(int'(c.pos), c.val);
               st.ok = 1'b1;
            end
         end
         CMD_REM_VAL: begin
            for (int i = 0; i < len && !found; i++) begin
               if (shadow_list[i] === c.val) begin
                  shadow_list.delete(i);
                  found = 1;
               end
            end
            st.ok = found;
         end
         CMD_REM_POS: begin
            if (int'(c.pos) < len) begin
               shadow_list.delete(int'(c.pos));
               st.ok = 1'b1;
            end
         end
         CMD_CLEAR: begin
            shadow_list.delete();
            st.ok = 1'b1;
         end
         default: ;
      endcase
      len = shadow_list.size();
      st.length   = LENGTH_W'(len);
      st.is_empty = (len == 0);
      st.is_full  = (len == CAPACITY);
      return st;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int r;
      logic [VALUE_W-1:0] v;
      r = $urandom_range(9);
      if (r < 5) begin
         // small pool so duplicates and hits on remove by value are common
         v = VALUE_W'(int'($urandom_range(8)) - 4);
      end else if (r < 8) begin
         v = $urandom;
      end else begin
         case ($urandom_range(3))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h0000_0000;
            default: v = 32'hFFFF_FFFF;
         endcase
      end
      return v;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(int len);
      if (len > 0 && $urandom_range(99) < 85)
         return POS_W'($urandom_range(len - 1, 0));
      return POS_W'($urandom);
   endfunction

   task automatic queue_cmd(logic [CMD_W-1:0] c, logic [POS_W-1:0] p,
                            logic [VALUE_W-1:0] v, phase_type ph);
      list_cmd_type item;
      item.cmd   = c;
      item.pos   = p;
      item.val   = v;
      item.phase = ph;
      cmd_pending.push_back(item);
      words_queued++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            status_expected.push_back(apply_list_command(cmd_in_flight));
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_pending.size() > 0 &&
                $urandom_range(99) >= send_idle_pct[cmd_pending[0].phase]) begin
               cmd_in_flight = cmd_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cmd_in_flight.val, cmd_in_flight.pos};
               req_tuser  <= cmd_in_flight.cmd;
               phase_now  <= cmd_in_flight.phase;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      list_status_type got;
      list_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.ok       = rsp_tdata[0];
            got.length   = rsp_tdata[7:1];
            got.is_empty = rsp_tdata[8];
            got.is_full  = rsp_tdata[9];
            if (status_expected.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("unexpected status word: ok=%0d length=%0d empty=%0d full=%0d",
                           got.ok, got.length, got.is_empty, got.is_full);
            end else begin
               want = status_expected.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("status mismatch: expected ok=%0d length=%0d empty=%0d full=%0d, %s",
                              want.ok, want.length, want.is_empty, want.is_full,
                              $sformatf("got ok=%0d length=%0d empty=%0d full=%0d",
                                        got.ok, got.length, got.is_empty, got.is_full));
               end
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(99) >= rsp_stall_pct[phase_now]);
      end
   end

   // long receiver hold-off while the sender keeps offering words
   initial begin
      wait (phase_now == PH_FREE);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      logic               filling;
      logic               do_insert;
      int                 len;
      int                 r;
      int                 n;
      logic [CMD_W-1:0]   c;
      logic [POS_W-1:0]   p;
      logic [VALUE_W-1:0] v;

      // directed: empty-list failures, extremes, bad positions, unknown commands, clear
      queue_cmd(CMD_REM_VAL,   8'd0,   32'h0000_0000, PH_DIRECTED);
      queue_cmd(CMD_REM_POS,   8'd0,   32'h0000_0000, PH_DIRECTED);
      queue_cmd(CMD_INS_POS,   8'd1,   32'h1234_5678, PH_DIRECTED);
      queue_cmd(CMD_INS_FRONT, 8'hFF,  32'h7FFF_FFFF, PH_DIRECTED);
      queue_cmd(CMD_INS_POS,   8'd0,   32'h8000_0000, PH_DIRECTED);
      queue_cmd(CMD_INS_POS,   8'd2,   32'h0000_0001, PH_DIRECTED);
      queue_cmd(CMD_INS_POS,   8'd1,   32'hFFFF_FFFF, PH_DIRECTED);
      queue_cmd(CMD_INS_POS,   8'hFF,  32'h0000_0002, PH_DIRECTED);
      queue_cmd(CMD_INS_FRONT, 8'd0,   32'h0000_0000, PH_DIRECTED);
      queue_cmd(CMD_REM_VAL,   8'd0,   32'h0000_3039, PH_DIRECTED);
      queue_cmd(CMD_REM_VAL,   8'hAA,  32'h8000_0000, PH_DIRECTED);
      queue_cmd(CMD_REM_POS,   8'hFF,  32'h0000_0000, PH_DIRECTED);
      queue_cmd(CMD_REM_POS,   8'd3,   32'h0000_0000, PH_DIRECTED);
      queue_cmd(CMD_REM_POS,   8'd1,   32'h5555_5555, PH_DIRECTED);
      queue_cmd(CMD_RSVD_MIN,  8'h55,  32'hAAAA_AAAA, PH_DIRECTED);
      queue_cmd(CMD_RSVD_MID,  8'hAA,  32'h5555_5555, PH_DIRECTED);
      queue_cmd(CMD_RSVD_MAX,  8'hFF,  32'hFFFF_FFFF, PH_DIRECTED);
      queue_cmd(CMD_CLEAR,     8'd0,   32'h0000_0000, PH_DIRECTED);
      queue_cmd(CMD_CLEAR,     8'hFF,  32'hFFFF_FFFF, PH_DIRECTED);
      queue_cmd(CMD_REM_VAL,   8'd0,   32'h7FFF_FFFF, PH_DIRECTED);

      // random: alternate between filling toward full and draining toward empty
      filling = 1'b1;
      for (int ph = PH_FREE; ph <= PH_BOTH; ph++) begin
         n = 0;
         while (n < ITEMS_PER_PHASE) begin
            wait (cmd_pending.size() == 0);
            repeat (4) begin
               len = shadow_list.size();
               if (len >= CAPACITY)
                  filling = 1'b0;
               else if (len == 0)
                  filling = 1'b1;
               r = $urandom_range(99);
               do_insert = filling ? (r < 83) : (r >= 83);
               p = pick_position(len);
               v = pick_value();
               if (r < 1) begin
                  c = CMD_CLEAR;
               end else if (r < 3) begin
                  c = CMD_W'($urandom_range(CMD_RSVD_MAX, CMD_RSVD_MIN));
                  p = POS_W'($urandom);
                  v = $urandom;
               end else if (do_insert) begin
                  c = $urandom_range(1) ? CMD_INS_FRONT : CMD_INS_POS;
               end else if ($urandom_range(1)) begin
                  c = CMD_REM_VAL;
                  if (len > 0 && $urandom_range(99) < 75)
                     v = shadow_list[$urandom_range(len - 1, 0)];
               end else begin
                  c = CMD_REM_POS;
               end
               queue_cmd(c, p, v, phase_type'(ph));
               n++;
            end
         end
      end

      wait (words_accepted == words_queued);
      wait (status_expected.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && status_expected.size() == 0) begin
         $display("bounded_ordered_list_engine_unit_test passed");
      end else begin
         $display("bounded_ordered_list_engine_unit_test failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("bounded_ordered_list_engine_unit_test failed");
      $finish;
   end

endmodule
